@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that hold in the same cycle as the trigger.
`define BMP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap check failed");

// Checks that hold in the cycle after the trigger.
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap check failed");

`endif

@@ hw/rtl/bmp_pkg.sv @@
`timescale 1ns / 1ps

package bmp_pkg;

   localparam int WORD_COUNT = 64;
   localparam int WORD_WIDTH = 64;

   localparam int IDX_W  = 12;
   localparam int MODE_W = 3;
   localparam int BIT_W  = $clog2(WORD_WIDTH);
   localparam int ADDR_W = $clog2(WORD_COUNT);
   localparam int WSEL_W = IDX_W - BIT_W;

   localparam logic [WSEL_W:0]   SEL_LIMIT = (WSEL_W + 1)'(WORD_COUNT);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);

   localparam logic [MODE_W-1:0] MODE_SET        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEST       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_CLEAR = 3'd4;
   localparam logic [MODE_W-1:0] MODE_INVERT     = 3'd5;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [WORD_COUNT-1:0] summary_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INV_RD,
      ST_INV_WR
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      word_type          wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             load;
      logic             found;
      logic [IDX_W-1:0] found_index;
      logic             bit_value;
   } res_type;

   function automatic logic [ADDR_W-1:0] lowest_word(summary_type v);
      logic [ADDR_W-1:0] r;
      r = '0;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = ADDR_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(word_type v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/bmp_if.sv @@
`timescale 1ns / 1ps

interface bmp_req_if
   import bmp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IDX_W-1:0]  bit_index;

   modport source (output valid, output mode, output bit_index, input ready);
   modport sink   (input valid, input mode, input bit_index, output ready);
endinterface

interface bmp_rsp_if
   import bmp_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] found_index;
   logic             bit_value;

   modport source (output valid, output found, output found_index, output bit_value,
                   input ready);
   modport sink   (input valid, input found, input found_index, input bit_value,
                   output ready);
endinterface

@@ hw/rtl/bmp_store.sv @@
`timescale 1ns / 1ps

module bmp_store
   import bmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type cmd,
   output word_type    rd_data
);

   word_type          word_mem [WORD_COUNT];
   word_type          rd_word_ff;
   logic              rd_vld_ff;
   logic [WORD_COUNT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         word_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= word_mem[cmd.rd_addr];
      end
   end

   // never-written words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= valid_ff[cmd.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

@@ hw/rtl/bmp_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_ctrl
   import bmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bmp_req_if.sink     req_if,
   input  logic        out_free,
   input  word_type    rd_data,
   output mem_req_type mem_req,
   output res_type     res
);

   state_type         state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [BIT_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              in_range_ff, in_range_in;
   logic              sum_hit_ff, sum_hit_in;
   summary_type       summary_ff, summary_in;

   logic [WSEL_W-1:0] word_sel;
   logic [ADDR_W-1:0] low_word;
   logic [BIT_W-1:0]  low_bit;
   logic [BIT_W-1:0]  bit_sel;
   logic              is_find;
   word_type          onehot;
   word_type          cleared;
   word_type          inverted;

   assign word_sel = req_if.bit_index[IDX_W-1:BIT_W];
   assign low_word = lowest_word(summary_ff);
   assign low_bit  = lowest_bit(rd_data);
   assign is_find  = (mode_ff == MODE_FIND) || (mode_ff == MODE_FIND_CLEAR);
   assign bit_sel  = is_find ? low_bit : pos_ff;
   assign onehot   = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << bit_sel;
   assign cleared  = rd_data & ~onehot;
   assign inverted = ~rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         summary_ff <= '0;
      end else begin
         state_ff   <= state_in;
         summary_ff <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      pos_ff      <= pos_in;
      addr_ff     <= addr_in;
      in_range_ff <= in_range_in;
      sum_hit_ff  <= sum_hit_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      in_range_in   = in_range_ff;
      sum_hit_in    = sum_hit_ff;
      summary_in    = summary_ff;
      req_if.ready  = 1'b0;
      mem_req       = '0;
      res           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               mode_in     = req_if.mode;
               pos_in      = req_if.bit_index[BIT_W-1:0];
               in_range_in = {1'b0, word_sel} < SEL_LIMIT;
               sum_hit_in  = |summary_ff;
               priority if (req_if.mode == MODE_FIND || req_if.mode == MODE_FIND_CLEAR) begin
                  addr_in = low_word;
               end else if (req_if.mode == MODE_INVERT) begin
                  addr_in = '0;
               end else begin
                  addr_in = word_sel[ADDR_W-1:0];
               end
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_in;
               state_in = (req_if.mode == MODE_INVERT) ? ST_INV_WR : ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               res.load        = 1'b1;
               state_in        = ST_IDLE;
               mem_req.wr_addr = addr_ff;
               unique case (mode_ff)
                  MODE_SET: begin
                     mem_req.wr_data = rd_data | onehot;
                     if (in_range_ff) begin
                        mem_req.wr_en       = 1'b1;
                        summary_in[addr_ff] = 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     mem_req.wr_data = cleared;
                     if (in_range_ff) begin
                        mem_req.wr_en = 1'b1;
                        if (cleared == '0) begin
                           summary_in[addr_ff] = 1'b0;
                        end
                     end
                  end
                  MODE_TEST: begin
                     res.bit_value = in_range_ff & rd_data[pos_ff];
                  end
                  MODE_FIND, MODE_FIND_CLEAR: begin
                     mem_req.wr_data = cleared;
                     if (sum_hit_ff) begin
                        res.found       = 1'b1;
                        res.found_index = IDX_W'({addr_ff, low_bit});
                        if (mode_ff == MODE_FIND_CLEAR) begin
                           mem_req.wr_en = 1'b1;
                           if (cleared == '0) begin
                              summary_in[addr_ff] = 1'b0;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INV_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = addr_ff;
            state_in        = ST_INV_WR;
         end

         ST_INV_WR: begin
            mem_req.wr_en       = 1'b1;
            mem_req.wr_addr     = addr_ff;
            mem_req.wr_data     = inverted;
            summary_in[addr_ff] = |inverted;
            if (addr_ff == LAST_WORD) begin
               state_in = ST_EXEC;
            end else begin
               addr_in  = addr_ff + 1'b1;
               state_in = ST_INV_RD;
            end
         end
      endcase
   end

   `BMP_ASSERT_NOW(a_no_rw_same_word, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr)
   `BMP_ASSERT_NOW(a_load_needs_slot, res.load, out_free)
   `BMP_ASSERT_NOW(a_found_word_nonempty, state_ff == ST_EXEC && sum_hit_ff && is_find, rd_data != '0)
   `BMP_ASSERT_NEXT(a_accept_leaves_idle, req_if.valid && req_if.ready, state_ff != ST_IDLE)

endmodule

@@ hw/rtl/two_level_bitmap_find_first.sv @@
`timescale 1ns / 1ps
// Channel   Dir   Fields
// req_if    in    mode, bit_index
// rsp_if    out   found, found_index, bit_value
//
// Set, clear, test and find do one word-memory read, then one modify/write-back step.
// Invert all sweeps the word memory read-then-write, from word 0 up to the last word.
// Reset clears per-word valid flags and the summary at once; no clearing pass.
// A result beat waits in the output register; a stalled rsp_if holds the
// block in its write-back cycle until the register frees.

module two_level_bitmap_find_first
   import bmp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bmp_req_if.sink   req_if,
   bmp_rsp_if.source rsp_if
);

   mem_req_type      mem_req;
   word_type         rd_data;
   res_type          res;
   logic             out_free;
   logic             rsp_valid_ff;
   logic             found_ff;
   logic [IDX_W-1:0] found_index_ff;
   logic             bit_value_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   bmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .out_free (out_free),
      .rd_data  (rd_data),
      .mem_req  (mem_req),
      .res      (res)
   );

   bmp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         found_ff       <= res.found;
         found_index_ff <= res.found_index;
         bit_value_ff   <= res.bit_value;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = found_ff;
   assign rsp_if.found_index = found_index_ff;
   assign rsp_if.bit_value   = bit_value_ff;

endmodule

@@ tb/tb_two_level_bitmap_find_first.sv @@
`timescale 1ns / 1ps

module tb_two_level_bitmap_find_first
   import bmp_pkg::*;
();

   localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 2 * WORD_COUNT + 8;
   localparam int RANDOM_OPS   = 950;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] found_index;
      logic             bit_value;
   } answer_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  bit_index;
      logic              typed;
      answer_type        answer;
   } plan_row_type;

   logic clock;
   logic reset;

   bmp_req_if req_if();
   bmp_rsp_if rsp_if();

   two_level_bitmap_find_first dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [WORD_WIDTH-1:0] shadow_words [WORD_COUNT];
   logic [WORD_COUNT-1:0] shadow_summary;
   answer_type            pending_answers [$];
   int                    errors;
   int                    cycles;
   bit                    calm;

   always #5 clock = ~clock;

   function automatic int first_one(logic [63:0] v);
      int r;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            r = i;
         end
      end
      return r;
   endfunction

   function automatic answer_type apply_bitmap_op(logic [MODE_W-1:0] mode,
                                                  logic [IDX_W-1:0] idx);
      answer_type a;
      int w;
      int b;
      a = '0;
      w = idx / WORD_WIDTH;
      b = idx % WORD_WIDTH;
      case (mode)
         MODE_SET: begin
            if (w < WORD_COUNT) begin
               shadow_words[w][b] = 1'b1;
               shadow_summary[w]  = 1'b1;
            end
         end
         MODE_CLEAR: begin
            if (w < WORD_COUNT) begin
               shadow_words[w][b] = 1'b0;
               if (shadow_words[w] == '0) shadow_summary[w] = 1'b0;
            end
         end
         MODE_TEST: begin
            if (w < WORD_COUNT) a.bit_value = shadow_words[w][b];
         end
         MODE_FIND, MODE_FIND_CLEAR: begin
            if (shadow_summary != '0) begin
               w = first_one(64'(shadow_summary));
               b = first_one(64'(shadow_words[w]));
               a.found       = 1'b1;
               a.found_index = IDX_W'(w * WORD_WIDTH + b);
               if (mode == MODE_FIND_CLEAR) begin
                  shadow_words[w][b] = 1'b0;
                  if (shadow_words[w] == '0) shadow_summary[w] = 1'b0;
               end
            end
         end
         MODE_INVERT: begin
            shadow_summary = '0;
            for (int i = 0; i < WORD_COUNT; i++) begin
               shadow_words[i] = ~shadow_words[i];
               if (shadow_words[i] != '0) shadow_summary[i] = 1'b1;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic plan_row_type row(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                                        logic typed, logic f, logic [IDX_W-1:0] fi,
                                        logic bv);
      plan_row_type p;
      p.mode      = mode;
      p.bit_index = idx;
      p.typed     = typed;
      p.answer    = '{found: f, found_index: fi, bit_value: bv};
      return p;
   endfunction

   task automatic send_op(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                          logic typed, answer_type lit);
      answer_type predicted;
      while (!calm && $urandom_range(99) < 8) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.mode      <= mode;
      req_if.bit_index <= idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = apply_bitmap_op(mode, idx);
      pending_answers.push_back(typed ? lit : predicted);
   endtask

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 28) return MODE_SET;
      if (r < 46) return MODE_CLEAR;
      if (r < 66) return MODE_TEST;
      if (r < 78) return MODE_FIND;
      if (r < 94) return MODE_FIND_CLEAR;
      if (r < 96) return MODE_INVERT;
      if (r < 98) return MODE_SPARE6;
      return MODE_SPARE7;
   endfunction

   always @(posedge clock) begin : rsp_check
      answer_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_if.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
                  errors++;
               end
               if (rsp_if.found_index !== want.found_index) begin
                  $error("found_index: expected %0d, actual %0d",
                         want.found_index, rsp_if.found_index);
                  errors++;
               end
               if (rsp_if.bit_value !== want.bit_value) begin
                  $error("bit_value: expected %0d, actual %0d",
                         want.bit_value, rsp_if.bit_value);
                  errors++;
               end
            end
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type          plan [$];
      logic [ADDR_W-1:0]     hot [4];
      logic [IDX_W-1:0]      idx;
      logic [MODE_W-1:0]     mode;
      int                    n;
      int                    burst;
      int                    q;

      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.mode      = MODE_SET;
      req_if.bit_index = '0;
      rsp_if.ready     = 1'b0;
      shadow_summary   = '0;
      for (int i = 0; i < WORD_COUNT; i++) shadow_words[i] = '0;
      errors = 0;
      cycles = 0;
      calm   = 1'b0;

      // empty set, extremes, word emptying, spare modes, invert both ways
      plan.push_back(row(MODE_FIND,       12'd0,    1, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND_CLEAR, 12'd0,    1, 0, 12'd0,    0));
      plan.push_back(row(MODE_TEST,       12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_SET,        12'd0,    1, 0, 12'd0,    0));
      plan.push_back(row(MODE_SET,        12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_TEST,       12'd4095, 1, 0, 12'd0,    1));
      plan.push_back(row(MODE_TEST,       12'd0,    1, 0, 12'd0,    1));
      plan.push_back(row(MODE_FIND,       12'hABC,  1, 1, 12'd0,    0));
      plan.push_back(row(MODE_FIND_CLEAR, 12'h543,  1, 1, 12'd0,    0));
      plan.push_back(row(MODE_FIND,       12'd0,    1, 1, 12'd4095, 0));
      plan.push_back(row(MODE_SET,        12'd4094, 0, 0, 12'd0,    0));
      plan.push_back(row(MODE_CLEAR,      12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND,       12'd0,    0, 0, 12'd0,    0));
      plan.push_back(row(MODE_CLEAR,      12'd4094, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND,       12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_SPARE6,     12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_SPARE7,     12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_INVERT,     12'd4095, 1, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND,       12'd0,    1, 1, 12'd0,    0));
      plan.push_back(row(MODE_TEST,       12'd2730, 1, 0, 12'd0,    1));
      plan.push_back(row(MODE_CLEAR,      12'd0,    0, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND_CLEAR, 12'd0,    0, 0, 12'd0,    0));
      plan.push_back(row(MODE_INVERT,     12'd0,    0, 0, 12'd0,    0));
      plan.push_back(row(MODE_FIND,       12'd0,    0, 0, 12'd0,    0));
      plan.push_back(row(MODE_TEST,       12'd1,    0, 0, 12'd0,    0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_op(plan[i].mode, plan[i].bit_index, plan[i].typed, plan[i].answer);

      for (int i = 0; i < 4; i++) hot[i] = ADDR_W'($urandom);
      n = 0;
      while (n < RANDOM_OPS) begin
         calm = (n >= 300 && n < 460);
         if ($urandom_range(99) < 5) hot[$urandom_range(3)] = ADDR_W'($urandom);
         if ($urandom_range(99) < 3) begin
            // drain run: pull the lowest bits out one after another
            burst = $urandom_range(5, 20);
            for (int k = 0; k < burst; k++) begin
               send_op(MODE_FIND_CLEAR, IDX_W'($urandom), 0, '0);
               n++;
            end
         end else begin
            mode = pick_mode();
            q = $urandom_range(9);
            if (q < 6)
               idx = {hot[$urandom_range(3)], BIT_W'($urandom)};
            else if (q < 8)
               idx = IDX_W'($urandom);
            else if (q == 8)
               idx = $urandom_range(1) ? '1 : '0;
            else
               idx = {hot[$urandom_range(3)], $urandom_range(1) ? {BIT_W{1'b1}} : {BIT_W{1'b0}}};
            send_op(mode, idx, 0, '0);
            n++;
         end
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
